/* hw/rtl/utx_pkg.sv */
// ----------------------------------------------------------------------------
// utx_pkg
// Types, constants and the UTF-8 encoder shared by the transcoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utx_pkg;

    localparam int LENGTH_BITS = 32;
    localparam logic [31:0] COUNT_MAX = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [15:0] SURR_END     = 16'hE000;
    localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
    localparam logic [31:0] LIM_1B       = 32'h0000_0080;
    localparam logic [31:0] LIM_2B       = 32'h0000_0800;
    localparam logic [31:0] LIM_3B       = 32'h0001_0000;
    localparam logic [31:0] LIM_4B       = 32'h0020_0000;
    localparam logic [7:0]  LEAD_2B      = 8'hC0;
    localparam logic [7:0]  LEAD_3B      = 8'hE0;
    localparam logic [7:0]  LEAD_4B      = 8'hF0;
    localparam logic [7:0]  CONT_BYTE    = 8'h80;
    localparam logic [7:0]  HASH_CHAR    = 8'h23;

    localparam logic FMT_UTF16 = 1'b0;
    localparam logic FMT_UTF32 = 1'b1;

    typedef struct packed {
        logic [31:0] code_unit;
        logic        end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic        last_of_run;
        logic        string_done;
        logic        halted;
        logic [31:0] total_length;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0] byte_seq;
        logic [2:0]      n_bytes;
    } t_enc;

    // one queued item: its bytes and end-of-string report
    typedef struct packed {
        logic [3:0][7:0] byte_seq;
        logic [2:0]      n_bytes;
        logic [2:0]      n_res;
        logic            eos;
        logic            halted;
        logic [31:0]     total;
    } t_job;

    function automatic t_enc utx_encode(input logic [31:0] cp);
        t_enc e;
        e.byte_seq = '0;
        e.n_bytes  = 3'd1;
        if (cp < LIM_1B) begin
            e.byte_seq[0] = cp[7:0];
        end else if (cp < LIM_2B) begin
            e.byte_seq[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.byte_seq[1] = CONT_BYTE | {2'b00, cp[5:0]};
            e.n_bytes     = 3'd2;
        end else if (cp < LIM_3B) begin
            e.byte_seq[0] = LEAD_3B | {4'b0000, cp[15:12]};
            e.byte_seq[1] = CONT_BYTE | {2'b00, cp[11:6]};
            e.byte_seq[2] = CONT_BYTE | {2'b00, cp[5:0]};
            e.n_bytes     = 3'd3;
        end else if (cp < LIM_4B) begin
            e.byte_seq[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.byte_seq[1] = CONT_BYTE | {2'b00, cp[17:12]};
            e.byte_seq[2] = CONT_BYTE | {2'b00, cp[11:6]};
            e.byte_seq[3] = CONT_BYTE | {2'b00, cp[5:0]};
            e.n_bytes     = 3'd4;
        end else begin
            e.byte_seq[0] = HASH_CHAR;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/utx_front.sv */
// ----------------------------------------------------------------------------
// utx_front
// Accepts code units, tracks surrogates, halt and byte count, builds jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_front
    import utx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_push,
    input  wire logic     i_q_ready,
    output t_job          o_job
);

    logic        r_fmt;
    logic [9:0]  r_held_bits, n_held_bits;
    logic        r_held_valid, n_held_valid;
    logic        r_halt, n_halt;
    logic [31:0] r_count, n_count;

    logic        accept;
    logic        eos;
    logic [15:0] x;
    logic        is_high, is_low;
    logic [31:0] cp;
    logic        do_enc;
    t_enc        enc;
    logic [2:0]  n_bytes;
    logic [32:0] sum;
    logic [31:0] cnt_upd;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign eos        = i_in_item.end_of_string;
    assign x          = i_in_item.code_unit[15:0];
    assign is_high    = (x >= SURR_HI_BASE) && (x < SURR_LO_BASE);
    assign is_low     = (x >= SURR_LO_BASE) && (x < SURR_END);

    always_comb begin
        n_held_bits  = r_held_bits;
        n_held_valid = r_held_valid;
        n_halt       = r_halt;
        do_enc       = 1'b0;
        cp           = {16'h0000, x};
        if (!r_halt) begin
            if (r_fmt == FMT_UTF32) begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
                do_enc       = 1'b1;
                cp           = i_in_item.code_unit;
            end else if (r_held_valid) begin
                if (is_low) begin
                    do_enc = 1'b1;
                    cp     = {12'h000, r_held_bits, x[9:0]} + SUPP_BASE;
                end else begin
                    n_halt = 1'b1;
                end
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end else if (is_high) begin
                if (eos) begin
                    n_halt = 1'b1;
                end else begin
                    n_held_valid = 1'b1;
                    n_held_bits  = x[9:0];
                end
            end else if (is_low) begin
                n_halt = 1'b1;
            end else begin
                do_enc = 1'b1;
            end
        end
    end

    assign enc     = utx_encode(cp);
    assign n_bytes = do_enc ? enc.n_bytes : 3'd0;
    assign sum     = {1'b0, r_count} + {30'd0, n_bytes};
    assign cnt_upd = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[31:0];
    assign n_count = cnt_upd;

    always_comb begin
        o_job.byte_seq = enc.byte_seq;
        o_job.n_bytes  = n_bytes;
        o_job.n_res    = (n_bytes == 3'd0) ? 3'd1 : n_bytes;
        o_job.eos      = eos;
        o_job.halted   = n_halt;
        o_job.total    = cnt_upd;
    end

    // items with no byte and no end report produce nothing
    assign o_push = accept && ((n_bytes != 3'd0) || eos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FMT_UTF16;
            r_held_bits  <= '0;
            r_held_valid <= 1'b0;
            r_halt       <= 1'b0;
            r_count      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fmt <= i_cfg_wr_data;
            end
            if (accept) begin
                if (eos) begin
                    r_held_bits  <= '0;
                    r_held_valid <= 1'b0;
                    r_halt       <= 1'b0;
                    r_count      <= '0;
                end else begin
                    r_held_bits  <= n_held_bits;
                    r_held_valid <= n_held_valid;
                    r_halt       <= n_halt;
                    r_count      <= n_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utx_queue.sv */
// ----------------------------------------------------------------------------
// utx_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_queue
    import utx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utx_back.sv */
// ----------------------------------------------------------------------------
// utx_back
// Takes jobs from the queue and sends out one result item per cycle while i_out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_back
    import utx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_q_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_item o_out_item
);

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       is_last;
    logic       has_byte;
    logic       take;

    assign is_last  = ({1'b0, r_idx} == (r_job.n_res - 3'd1));
    assign has_byte = ({1'b0, r_idx} < r_job.n_bytes);
    assign take     = r_busy && i_out_ready;
    assign o_pop    = i_q_valid && (!r_busy || (take && is_last));

    assign o_out_valid = r_busy;

    always_comb begin
        o_out_item.out_byte     = has_byte ? r_job.byte_seq[r_idx] : 8'h00;
        o_out_item.byte_present = has_byte;
        o_out_item.last_of_run  = is_last;
        o_out_item.string_done  = is_last && r_job.eos;
        o_out_item.halted       = is_last && r_job.eos && r_job.halted;
        o_out_item.total_length = (is_last && r_job.eos) ? r_job.total : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utf16_utf32_to_utf8_transcoder.sv */
// path: accepted items are registered in the job queue, then in the back end job register
// throughput: one result item per cycle while i_out_ready is high; an item gives 1 to 4
// result items (its byte count, or one marker item if it has no byte), set by the back
// end serialiser; single-result items stream one per cycle through the two-entry queue
// reset: synchronous active-low i_rst_n clears format to utf-16, all string
// state and the queue; no clearing pass is needed
// ----------------------------------------------------------------------------
// utf16_utf32_to_utf8_transcoder
// Converts utf-16 or utf-32 code units into a stream of utf-8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_utf32_to_utf8_transcoder
    import utx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    logic push, q_ready, q_valid, pop;
    t_job front_job, q_job;

    utx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_push        (push),
        .i_q_ready     (q_ready),
        .o_job         (front_job)
    );

    utx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    utx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/utx_checker.sv */
// ----------------------------------------------------------------------------
// utx_checker
// Port-level checks on the transcoder result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_checker
    import utx_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_ready,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_item
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // end of string only on the last result of an item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.string_done |-> o_out_item.last_of_run)
        else $error("string_done without last_of_run");

    // a marker item carries no byte and closes the string
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_present
            |-> o_out_item.string_done && (o_out_item.out_byte == 8'h00))
        else $error("marker item outside end of string");

    // halt and length are reported only with end of string
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.string_done
            |-> !o_out_item.halted && (o_out_item.total_length == 32'd0))
        else $error("report fields set before end of string");

endmodule

bind utf16_utf32_to_utf8_transcoder utx_checker u_utx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item)
);

`default_nettype wire
